/* rtl/msort_pkg.sv */
// shared types and constants of the merge sorter
`timescale 1ns / 1ps

package msort_pkg;

   // width of one stored element
   localparam int DATA_W = 32;

   // one signed element as it moves through the sorter
   typedef logic signed [DATA_W-1:0] data_type;

endpackage

/* rtl/merge_sorter_unit.sv */
// merge sorter top level: set capture, bottom-up merge passes and sorted output
//
// The req_ channel takes one signed value per item. The item with req_final_item
// high closes the set. Up to MAX_ITEMS values are kept; later values of the same
// set are dropped, and a final item still closes the set when it arrives past
// capacity. Then the set is merge-sorted in place between two halves of one
// buffer RAM and sent out on the rsp_ channel in ascending order, with
// rsp_final_result high on the last value.
// Sequence for a set of n values: capture takes every offered item without
// stalling, then ceil(log2 n) merge passes follow; each pass opens with a pass
// check, sets up each pair of runs in turn and, per element, reads the RAM, then
// compares and writes through the single compare unit. A last pass check starts
// the output. For each value the output reads the RAM, then loads the output
// register. req_stall stays high from the final item until the last value
// has been loaded into the output register.
// A stall on rsp_ holds the output register and pauses the output sequencer;
// a new set may be captured while the last value still waits to be taken.
// Reset (synchronous, active high) empties the set, clears the output valid
// and returns the sequencer to capture; the RAM is not cleared.
`timescale 1ns / 1ps

module merge_sorter_unit #(
   parameter int MAX_ITEMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  msort_pkg::data_type req_value,
   input  logic               req_final_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output msort_pkg::data_type rsp_sorted_value,
   output logic               rsp_final_result
);

   import msort_pkg::*;

   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int NW    = $clog2(MAX_ITEMS + 1);
   localparam int CW    = AW + 2;
   localparam int DEPTH = 2 ** (AW + 1);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_RUN,
      ST_READ,
      ST_MERGE,
      ST_EMIT_READ,
      ST_EMIT_WAIT
   } state_type;

   // sequencer registers
   state_type        state_ff, state_in;
   logic [NW-1:0]    count_ff, count_in;
   logic [NW-1:0]    n_ff, n_in;
   logic [NW-1:0]    out_idx_ff, out_idx_in;
   logic [CW-1:0]    width_ff, width_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    mid_ff, mid_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [CW-1:0]    a_ff, a_in;
   logic [CW-1:0]    b_ff, b_in;
   logic [CW-1:0]    k_ff, k_in;
   logic             src_sel_ff, src_sel_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   data_type         rsp_value_ff, rsp_value_in;
   logic             rsp_final_ff, rsp_final_in;

   // buffer ram: lower half and upper half take turns as source and target
   data_type         mem [DEPTH];
   data_type         rd_a_ff;
   data_type         rd_b_ff;
   logic [AW:0]      rd_addr_a;
   logic [AW:0]      rd_addr_b;
   logic [AW:0]      wr_addr;
   logic             wr_en;
   data_type         wr_data;

   // helper terms
   logic             req_take;
   logic             has_room;
   logic [CW-1:0]    n_ext;
   logic [CW-1:0]    lo_plus_w;
   logic [CW-1:0]    lo_plus_2w;
   logic             a_live;
   logic             b_live;
   logic             take_a;
   logic             out_free;
   logic             last_out;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign has_room  = (count_ff < NW'(MAX_ITEMS));
   assign n_ext     = CW'(n_ff);

   // run bounds before clamping; ST_RUN clamps them to the set size
   assign lo_plus_w  = lo_ff + width_ff;
   assign lo_plus_2w = lo_ff + (width_ff << 1);

   // shared compare unit: ties go to the second run
   assign a_live  = (a_ff < mid_ff);
   assign b_live  = (b_ff < hi_ff);
   assign take_a  = a_live && (!b_live || (rd_a_ff < rd_b_ff));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_out = (out_idx_ff == (n_ff - NW'(1)));

   // ram port selection
   always_comb begin
      if (state_ff == ST_EMIT_READ || state_ff == ST_EMIT_WAIT) begin
         rd_addr_a = {src_sel_ff, out_idx_ff[AW-1:0]};
      end else begin
         rd_addr_a = {src_sel_ff, a_ff[AW-1:0]};
      end
      rd_addr_b = {src_sel_ff, b_ff[AW-1:0]};
      if (state_ff == ST_MERGE) begin
         wr_en   = 1'b1;
         wr_addr = {!src_sel_ff, k_ff[AW-1:0]};
         wr_data = take_a ? rd_a_ff : rd_b_ff;
      end else begin
         wr_en   = req_take && has_room;
         wr_addr = {1'b0, count_ff[AW-1:0]};
         wr_data = req_value;
      end
   end

   // buffer ram with registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      out_idx_in   = out_idx_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      src_sel_in   = src_sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;

      unique case (state_ff)
         // capture items until the final one
         ST_LOAD: begin
            if (req_take) begin
               if (req_final_item) begin
                  n_in       = has_room ? (count_ff + NW'(1)) : count_ff;
                  count_in   = '0;
                  width_in   = CW'(1);
                  src_sel_in = 1'b0;
                  state_in   = ST_PASS;
               end else if (has_room) begin
                  count_in = count_ff + NW'(1);
               end
            end
         end
         // start a pass, or go to output when one run covers the set
         ST_PASS: begin
            if (width_ff >= n_ext) begin
               out_idx_in = '0;
               state_in   = ST_EMIT_READ;
            end else begin
               lo_in    = '0;
               state_in = ST_RUN;
            end
         end
         // set up the next pair of runs, or close the pass
         ST_RUN: begin
            if (lo_ff >= n_ext) begin
               src_sel_in = !src_sel_ff;
               width_in   = width_ff << 1;
               state_in   = ST_PASS;
            end else begin
               mid_in   = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
               hi_in    = (lo_plus_2w < n_ext) ? lo_plus_2w : n_ext;
               a_in     = lo_ff;
               b_in     = (lo_plus_w < n_ext) ? lo_plus_w : n_ext;
               k_in     = lo_ff;
               state_in = ST_READ;
            end
         end
         // ram read of both run heads
         ST_READ: begin
            state_in = ST_MERGE;
         end
         // compare, write the smaller head, advance
         ST_MERGE: begin
            if (take_a) begin
               a_in = a_ff + CW'(1);
            end else begin
               b_in = b_ff + CW'(1);
            end
            k_in = k_ff + CW'(1);
            if ((k_ff + CW'(1)) == hi_ff) begin
               lo_in    = hi_ff;
               state_in = ST_RUN;
            end else begin
               state_in = ST_READ;
            end
         end
         // ram read of the next sorted value
         ST_EMIT_READ: begin
            state_in = ST_EMIT_WAIT;
         end
         // load the output register once it is free
         ST_EMIT_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_a_ff;
               rsp_final_in = last_out;
               out_idx_in   = out_idx_ff + NW'(1);
               state_in     = last_out ? ST_LOAD : ST_EMIT_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      out_idx_ff   <= out_idx_in;
      width_ff     <= width_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      src_sel_ff   <= src_sel_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_result = rsp_final_ff;

   // fill count never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_ITEMS))
      else $error("fill count above capacity");

   // merge pointers stay inside their runs and account for every written slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |->
         (a_ff <= mid_ff) && (b_ff <= hi_ff) && (k_ff < hi_ff) &&
         ((k_ff + mid_ff) == (a_ff + b_ff)))
      else $error("merge pointers out of step");

   // a final item always starts the sort and blocks the input
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_final_item) |=> (state_ff == ST_PASS))
      else $error("final item did not start the sort");

endmodule

/* verif/merge_sorter_checker.sv */
// checker for the merge sorter: predicts the sorted output of each set and compares results
`timescale 1ns / 1ps

module merge_sorter_checker #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  msort_pkg::data_type req_value,
   input  logic                req_final_item,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  msort_pkg::data_type rsp_sorted_value,
   input  logic                rsp_final_result,
   output int                  fail_count,
   output int                  pending_count
);
   import msort_pkg::*;

   // one value of a sorted set as it should leave the block
   typedef struct packed {
      data_type value;
      logic     last;
   } sorted_entry_type;

   data_type         set_values[$];
   sorted_entry_type sorted_queue[$];
   int               mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("checker: mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // an item joins the set while there is room; a final item closes it
   task automatic capture_item();
      data_type         held;
      sorted_entry_type entry;
      int               j;
      if (set_values.size() < MAX_ITEMS) begin
         set_values.push_back(req_value);
      end
      if (req_final_item) begin
         // insertion sort, ascending
         for (int i = 1; i < set_values.size(); i++) begin
            held = set_values[i];
            j = i - 1;
            while (j >= 0 && set_values[j] > held) begin
               set_values[j+1] = set_values[j];
               j--;
            end
            set_values[j+1] = held;
         end
         for (int i = 0; i < set_values.size(); i++) begin
            entry.value = set_values[i];
            entry.last  = (i == set_values.size() - 1);
            sorted_queue.push_back(entry);
         end
         set_values.delete();
      end
   endtask

   // compare one taken result with the oldest expected value
   task automatic check_result();
      sorted_entry_type want;
      if (sorted_queue.size() == 0) begin
         report_mismatch($sformatf("result %0d with nothing expected", rsp_sorted_value));
      end else begin
         want = sorted_queue.pop_front();
         if (rsp_sorted_value !== want.value) begin
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      rsp_sorted_value, want.value));
         end
         if (rsp_final_result !== want.last) begin
            report_mismatch($sformatf("final_result %b, expected %b on value %0d",
                                      rsp_final_result, want.last, want.value));
         end
      end
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         set_values.delete();
         sorted_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) capture_item();
      end
      pending_count = sorted_queue.size();
      fail_count = mismatches;
   end

endmodule

/* verif/tb_top.sv */
// testbench top for the merge sorter: clock, reset, set stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import msort_pkg::*;

   localparam int MAX_ITEMS    = 64;
   localparam int RANDOM_ITEMS = 88;
   localparam int SETTLE       = 1500;
   localparam int CYCLE_LIMIT  = 1000000;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   data_type req_value = '0;
   logic     req_final_item = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   data_type rsp_sorted_value;
   logic     rsp_final_result;
   int       fail_count;
   int       pending_count;
   int       cycle_count = 0;
   logic     steady = 1'b0;
   data_type pattern[$];

   merge_sorter_unit #(
      .MAX_ITEMS(MAX_ITEMS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_final_item(req_final_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_final_result(rsp_final_result)
   );

   merge_sorter_checker #(
      .MAX_ITEMS(MAX_ITEMS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_final_item(req_final_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_final_result(rsp_final_result),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls about a third of the time, never in the steady stretch
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mix of tiny values for duplicates, extremes and full-range values
   function automatic data_type random_value();
      int pick;
      int tiny;
      pick = $urandom_range(0, 99);
      tiny = $urandom_range(0, 8);
      if (pick < 25) return data_type'(tiny - 4);
      if (pick < 35) begin
         case ($urandom_range(0, 3))
            0: return data_type'(32'h7fff_ffff);
            1: return data_type'(32'h8000_0000);
            2: return data_type'(32'h0000_0000);
            default: return data_type'(32'hffff_ffff);
         endcase
      end
      return data_type'($urandom);
   endfunction

   // offer one item, with random gaps, and hold it until taken
   task automatic send_item(input data_type value, input logic last);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_value      <= value;
      req_final_item <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // send the current pattern as one set
   task automatic send_pattern();
      for (int i = 0; i < pattern.size(); i++) begin
         send_item(pattern[i], i == pattern.size() - 1);
      end
   endtask

   // hold off until every sorted value is out
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int random_items;
      int set_size;
      logic big_done;
      random_items = 0;
      big_done = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single item set at the top value
      pattern = {data_type'(32'h7fff_ffff)};
      send_pattern();
      // two extremes in reverse order
      pattern = {data_type'(32'h7fff_ffff), data_type'(32'h8000_0000)};
      send_pattern();
      // already ascending, across the sign boundary
      pattern = {data_type'(32'h8000_0000), data_type'(-1), data_type'(0),
                 data_type'(1), data_type'(32'h7fff_ffff)};
      send_pattern();
      // equal values
      pattern = {data_type'(5), data_type'(5), data_type'(-5), data_type'(5),
                 data_type'(-5), data_type'(0)};
      send_pattern();
      // descending run of eight
      pattern.delete();
      for (int i = 7; i >= 0; i--) pattern.push_back(data_type'(i * 1000 - 3500));
      send_pattern();
      drain();

      // random sets: mostly small, some medium, one past capacity
      while (random_items < RANDOM_ITEMS) begin
         if (!big_done && random_items >= 30) begin
            set_size = MAX_ITEMS + 3;
            big_done = 1'b1;
         end else if ($urandom_range(0, 7) == 0) begin
            set_size = $urandom_range(9, 24);
         end else begin
            set_size = $urandom_range(1, 8);
         end
         for (int k = 0; k < set_size; k++) begin
            steady = (random_items >= 15 && random_items < 60);
            send_item(random_value(), k == set_size - 1);
            random_items++;
         end
         if ($urandom_range(0, 5) == 0) drain();
      end
      steady = 1'b0;

      // wait for the last set, then give late results a chance to show
      drain();
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/msort_pkg.sv
rtl/merge_sorter_unit.sv
verif/merge_sorter_checker.sv
verif/tb_top.sv
